@@ sv/pss_pkg.sv @@
// Shared types and constants for the partial shuffle sampler.
package pss_pkg;

  // Widths of the configuration registers and of the result value.
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned VAL_W       = 11;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;

  // Draw tag kept beside every permutation entry.
  localparam int unsigned EPOCH_W = 8;

  // Depth of the small queues; must be a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_POPULATION_SIZE = 1'b0,
    REG_PICK_COUNT      = 1'b1
  } pss_reg_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_DRAIN,
    ST_RUN
  } pss_state_e;

  // Control that travels from the issue unit to the execute unit.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               sweep;
    logic [EPOCH_W-1:0] epoch;
  } pss_ctl_t;

  // Status that travels back from the execute unit.
  typedef struct packed {
    logic en;
    logic busy;
  } pss_sts_t;

endpackage

@@ sv/pss_fifo.sv @@
// Small first-in first-out queue used on the input and result sides.
module pss_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import pss_pkg::*;

  logic [WIDTH-1:0]  store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign do_push = push_i && (!full_o || pop_i);
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  // A push into a full queue is only legal when a pop frees a slot at once.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o) |-> pop_i)
    else $error("pss_fifo: push into a full queue without a pop");

endmodule

@@ sv/pss_issue.sv @@
// Issue unit: step and draw bookkeeping, memory sweep control and the scaling multiply.
module pss_issue #(
  parameter int unsigned MAX_POPULATION = 1024,
  parameter int unsigned FRACTION_BITS  = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [pss_pkg::CFG_W-1:0]                 pop_size_i,
  input  logic [pss_pkg::CFG_W-1:0]                 pick_cnt_i,
  input  logic                                      head_valid_i,
  input  logic [FRACTION_BITS-1:0]                  head_frac_i,
  output logic                                      pop_o,
  input  pss_pkg::pss_sts_t                         sts_i,
  output pss_pkg::pss_ctl_t                         ctl_o,
  output logic [$clog2(MAX_POPULATION+1)-1:0]       idx_o,
  output logic [$clog2(MAX_POPULATION+1)-1:0]       scaled_o,
  output logic [$clog2(MAX_POPULATION+1)-1:0]       size_o,
  output logic [$clog2(MAX_POPULATION)-1:0]         sweep_addr_o
);
  import pss_pkg::*;

  localparam int unsigned NW = $clog2(MAX_POPULATION + 1);
  localparam int unsigned AW = $clog2(MAX_POPULATION);
  localparam int unsigned SW = (CFG_W > NW) ? CFG_W : NW;
  localparam int unsigned PW = FRACTION_BITS + NW;

  pss_state_e         st_q, st_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [NW-1:0]      step_q, step_d;

  logic [SW-1:0] pop_w, pick_w, max_w, n_sat, k_one, k_sat;
  logic [NW-1:0] n_eff, k_eff, i_eff, m_len;
  logic [NW:0]   i_next;
  logic          new_draw, last, need_sweep, issue;
  logic [EPOCH_W-1:0] ep_issue;

  // Stage 1: issued item; stage 2: scaled offset.
  logic                     s1_v_q, s2_v_q;
  logic                     s1_last_q, s2_last_q;
  logic [EPOCH_W-1:0]       s1_ep_q, s2_ep_q;
  logic [NW-1:0]            s1_i_q, s2_i_q;
  logic [NW-1:0]            s1_n_q, s2_n_q;
  logic [NW-1:0]            s1_m_q, s2_sc_q;
  logic [FRACTION_BITS-1:0] s1_u_q;
  logic [PW-1:0]            prod;

  always_comb begin
    pop_w  = SW'(pop_size_i);
    pick_w = SW'(pick_cnt_i);
    max_w  = SW'(MAX_POPULATION);
    if (pop_w == '0) begin
      n_sat = SW'(1);
    end else if (pop_w > max_w) begin
      n_sat = max_w;
    end else begin
      n_sat = pop_w;
    end
    k_one = (pick_w == '0) ? SW'(1) : pick_w;
    k_sat = (k_one > n_sat) ? n_sat : k_one;
    n_eff = NW'(n_sat);
    k_eff = NW'(k_sat);
  end

  assign i_eff      = (step_q >= n_eff) ? '0 : step_q;
  assign new_draw   = (i_eff == '0);
  assign i_next     = {1'b0, i_eff} + (NW + 1)'(1);
  assign last       = (i_next >= {1'b0, k_eff});
  assign m_len      = n_eff - i_eff;
  assign need_sweep = new_draw && (epoch_q == '1);
  assign ep_issue   = new_draw ? epoch_q + EPOCH_W'(1) : epoch_q;

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    epoch_d = epoch_q;
    step_d  = step_q;
    issue   = 1'b0;
    unique case (st_q)
      ST_SWEEP: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(MAX_POPULATION - 1)) begin
          st_d    = ST_RUN;
          epoch_d = '0;
        end
      end
      ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q && !sts_i.busy) begin
          st_d  = ST_SWEEP;
          cnt_d = '0;
        end
      end
      ST_RUN: begin
        if (head_valid_i && need_sweep) begin
          st_d = ST_DRAIN;
        end else if (head_valid_i && sts_i.en) begin
          issue   = 1'b1;
          epoch_d = ep_issue;
          step_d  = last ? '0 : NW'(i_next);
        end
      end
      default: begin
        st_d = ST_SWEEP;
      end
    endcase
  end

  assign pop_o = issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_SWEEP;
      cnt_q   <= '0;
      epoch_q <= '0;
      step_q  <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      epoch_q <= epoch_d;
      step_q  <= step_d;
      if (sts_i.en) begin
        s1_v_q <= issue;
        s2_v_q <= s1_v_q;
      end
    end
  end

  assign prod = {{NW{1'b0}}, s1_u_q} * {{FRACTION_BITS{1'b0}}, s1_m_q};

  always_ff @(posedge clk_i) begin
    if (sts_i.en) begin
      if (issue) begin
        s1_last_q <= last;
        s1_ep_q   <= ep_issue;
        s1_i_q    <= i_eff;
        s1_n_q    <= n_eff;
        s1_m_q    <= m_len;
        s1_u_q    <= head_frac_i;
      end
      s2_last_q <= s1_last_q;
      s2_ep_q   <= s1_ep_q;
      s2_i_q    <= s1_i_q;
      s2_n_q    <= s1_n_q;
      s2_sc_q   <= prod[FRACTION_BITS +: NW];
    end
  end

  assign ctl_o.valid   = s2_v_q;
  assign ctl_o.last    = s2_last_q;
  assign ctl_o.sweep   = (st_q == ST_SWEEP);
  assign ctl_o.epoch   = s2_ep_q;
  assign idx_o         = s2_i_q;
  assign scaled_o      = s2_sc_q;
  assign size_o        = s2_n_q;
  assign sweep_addr_o  = cnt_q;

  // The sweep owns the write port, so the pipeline must be empty.
  a_sweep_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SWEEP) |-> (!s1_v_q && !s2_v_q))
    else $error("pss_issue: sweep while items are in flight");

  // Tag zero marks swept entries and is never handed to an item.
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (s1_v_q && s1_ep_q != '0))
    else $error("pss_issue: item issued with the reserved tag");

endmodule

@@ sv/pss_exec.sv @@
// Execute unit: permutation memory, swap with forwarding, result queue.
module pss_exec #(
  parameter int unsigned MAX_POPULATION = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pss_pkg::pss_ctl_t                   ctl_i,
  input  logic [$clog2(MAX_POPULATION+1)-1:0] idx_i,
  input  logic [$clog2(MAX_POPULATION+1)-1:0] scaled_i,
  input  logic [$clog2(MAX_POPULATION+1)-1:0] size_i,
  input  logic [$clog2(MAX_POPULATION)-1:0]   sweep_addr_i,
  output pss_pkg::pss_sts_t                   sts_o,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output logic [pss_pkg::VAL_W-1:0]           m_value_o,
  output logic                                m_last_o
);
  import pss_pkg::*;

  localparam int unsigned NW = $clog2(MAX_POPULATION + 1);
  localparam int unsigned AW = $clog2(MAX_POPULATION);
  localparam int unsigned EW = EPOCH_W + AW;

  logic [EW-1:0] mem_q [MAX_POPULATION];

  logic [NW:0]   j_sum, j_sel;
  logic [AW-1:0] i_addr, j_addr;
  logic          en, wr_en, out_full, out_pop;

  logic               s3_v_q, s3_last_q;
  logic [EPOCH_W-1:0] s3_ep_q;
  logic [AW-1:0]      s3_i_q, s3_j_q;
  logic [EW-1:0]      rd_i_q, rd_j_q;

  logic               fwd_v_q;
  logic [EPOCH_W-1:0] fwd_ep_q;
  logic [AW-1:0]      fwd_addr_q, fwd_val_q;

  logic [AW-1:0]      val_a, val_b;
  logic               fwd_a, fwd_b;
  logic [AW:0]        b_plus;
  logic [VAL_W:0]     out_word;
  logic [VAL_W:0]     q_word;

  // Partner index, clamped to the last entry of the population.
  assign j_sum  = {1'b0, idx_i} + {1'b0, scaled_i};
  assign j_sel  = (j_sum >= {1'b0, size_i}) ? ({1'b0, size_i} - (NW + 1)'(1)) : j_sum;
  assign i_addr = idx_i[AW-1:0];
  assign j_addr = j_sel[AW-1:0];

  assign out_pop = m_valid_o && m_ready_i;
  assign en      = !(s3_v_q && out_full && !out_pop);
  assign wr_en   = en && s3_v_q;

  assign sts_o.en   = en;
  assign sts_o.busy = s3_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rd_i_q <= mem_q[i_addr];
      rd_j_q <= mem_q[j_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sweep) begin
      mem_q[sweep_addr_i] <= '0;
    end else if (wr_en) begin
      mem_q[s3_j_q] <= {s3_ep_q, val_a};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q  <= ctl_i.valid;
      fwd_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_last_q  <= ctl_i.last;
      s3_ep_q    <= ctl_i.epoch;
      s3_i_q     <= i_addr;
      s3_j_q     <= j_addr;
      fwd_ep_q   <= s3_ep_q;
      fwd_addr_q <= s3_j_q;
      fwd_val_q  <= val_a;
    end
  end

  // The write of the item just ahead lands in the same cycle as our read,
  // so it is taken from the forwarding register instead of the memory.
  always_comb begin
    fwd_a = fwd_v_q && (fwd_ep_q == s3_ep_q) && (fwd_addr_q == s3_i_q);
    fwd_b = fwd_v_q && (fwd_ep_q == s3_ep_q) && (fwd_addr_q == s3_j_q);
    if (fwd_a) begin
      val_a = fwd_val_q;
    end else if (rd_i_q[AW +: EPOCH_W] == s3_ep_q) begin
      val_a = rd_i_q[AW-1:0];
    end else begin
      val_a = s3_i_q;
    end
    if (fwd_b) begin
      val_b = fwd_val_q;
    end else if (rd_j_q[AW +: EPOCH_W] == s3_ep_q) begin
      val_b = rd_j_q[AW-1:0];
    end else begin
      val_b = s3_j_q;
    end
  end

  assign b_plus   = {1'b0, val_b} + (AW + 1)'(1);
  assign out_word = {s3_last_q, VAL_W'(b_plus)};

  pss_fifo #(
    .WIDTH (VAL_W + 1)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wr_en),
    .data_i  (out_word),
    .full_o  (out_full),
    .pop_i   (out_pop),
    .valid_o (m_valid_o),
    .data_o  (q_word)
  );

  assign m_value_o = q_word[VAL_W-1:0];
  assign m_last_o  = q_word[VAL_W];

  // No item may be in flight while the sweep drives the write port.
  a_sweep_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.sweep |-> (!s3_v_q && !ctl_i.valid))
    else $error("pss_exec: item in flight during the memory sweep");

endmodule

@@ sv/partial_shuffle_sampler.sv @@
// Top level of the partial shuffle sampler: ports, registers and unit wiring.
// A result passes the input queue, issue and execute stages and result queue.
// Throughput: one pick per cycle while the result side is not stalled and no
// sweep runs, set by the single write port of the permutation memory; one
// beat in each direction can be taken per cycle. Reset: asynchronous and
// active low, then a sweep clears every memory entry; once the pipeline has
// drained, the sweep recurs after every 255 draws, when the draw tag wraps.
// No pick issues during a sweep; input beats wait in the two-deep input queue.
module partial_shuffle_sampler #(
  parameter int unsigned MAX_POPULATION = 1024,
  parameter int unsigned FRACTION_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input beats: [FRACTION_BITS-1:0] uniform_fraction, zero padding above.
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [((FRACTION_BITS+7)/8)*8-1:0]   s_axis_tdata_i,
  // Result beats: [10:0] picked_value, zero padding above; tlast is last_pick.
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [pss_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tlast_o,
  // Register port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pss_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [pss_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [pss_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                 pready
);
  import pss_pkg::*;

  localparam int unsigned NW = $clog2(MAX_POPULATION + 1);
  localparam int unsigned AW = $clog2(MAX_POPULATION);

  // Configuration registers. Writes are only expected between draws, so the
  // issue unit samples them freely for each item.
  logic [CFG_W-1:0] pop_size_q, pick_cnt_q;
  logic             cfg_wr;
  pss_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = pss_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q <= CFG_W'(1024);
      pick_cnt_q <= CFG_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_POPULATION_SIZE: pop_size_q <= pwdata[CFG_W-1:0];
        REG_PICK_COUNT:      pick_cnt_q <= pwdata[CFG_W-1:0];
        default:             pop_size_q <= pop_size_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_POPULATION_SIZE: prdata = APB_DATA_W'(pop_size_q);
      REG_PICK_COUNT:      prdata = APB_DATA_W'(pick_cnt_q);
      default:             prdata = '0;
    endcase
  end

  // Front end: the input queue decouples the stream from the issue unit, so
  // beats keep flowing while the back end waits, until the input queue fills.
  logic                     in_full, head_valid, head_pop;
  logic [FRACTION_BITS-1:0] head_frac;

  assign s_axis_tready_o = !in_full;

  pss_fifo #(
    .WIDTH (FRACTION_BITS)
  ) u_input_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid_i && s_axis_tready_o),
    .data_i  (s_axis_tdata_i[FRACTION_BITS-1:0]),
    .full_o  (in_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_frac)
  );

  // Back end: the issue unit tracks the step within the draw and scales the
  // fraction to the partner index; the execute unit performs the swap.
  pss_ctl_t      ctl;
  pss_sts_t      sts;
  logic [NW-1:0] idx, scaled, size;
  logic [AW-1:0] sweep_addr;
  logic [VAL_W-1:0] value;

  pss_issue #(
    .MAX_POPULATION (MAX_POPULATION),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_issue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_size_i   (pop_size_q),
    .pick_cnt_i   (pick_cnt_q),
    .head_valid_i (head_valid),
    .head_frac_i  (head_frac),
    .pop_o        (head_pop),
    .sts_i        (sts),
    .ctl_o        (ctl),
    .idx_o        (idx),
    .scaled_o     (scaled),
    .size_o       (size),
    .sweep_addr_o (sweep_addr)
  );

  pss_exec #(
    .MAX_POPULATION (MAX_POPULATION)
  ) u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .idx_i        (idx),
    .scaled_i     (scaled),
    .size_i       (size),
    .sweep_addr_i (sweep_addr),
    .sts_o        (sts),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_value_o    (value),
    .m_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(value);

endmodule

@@ sim/partial_shuffle_sampler_tb.sv @@
// Testbench for the partial shuffle sampler: predicts each pick and checks every result beat.
`timescale 1ns / 1ps

module partial_shuffle_sampler_tb;
  import pss_pkg::*;

  localparam int unsigned MAX_POP     = 1024;
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned CLK_HALF    = 10;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned HOLD_CYC    = 200;
  localparam int unsigned RANDOM_PICKS = 400;

  // One expected result beat: the one-based value and the end-of-draw flag.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } pick_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_tvalid;
  logic                    s_tready;
  // Fraction beat: [31:0] uniform_fraction.
  logic [FRAC_W-1:0]       s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  // Result beat: [10:0] picked_value, [15:11] zero padding.
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic                    m_tlast;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [APB_DATA_W-1:0]   pwdata;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // Fractions waiting for the driver, and picks waiting for their result beat.
  logic [FRAC_W-1:0]       fraction_q[$];
  pick_t                   expected_picks[$];

  // Shadow of the sampler: registers, permutation entries and draw position.
  logic [CFG_W-1:0]        pop_size_reg;
  logic [CFG_W-1:0]        pick_cnt_reg;
  logic [9:0]              perm_entry[MAX_POP];
  logic [MAX_POP-1:0]      entry_live;
  logic [CFG_W-1:0]        draw_step;

  int unsigned             errors;
  logic                    quiet;
  int unsigned             holds_asked;
  int unsigned             holds_served;
  int unsigned             hold_left;

  partial_shuffle_sampler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Register values as the sampler uses them: zero counts as one, and the
  // population is capped at the store depth, the pick count at the population.
  function automatic int unsigned eff_population();
    if (pop_size_reg == 0) return 1;
    if (pop_size_reg > MAX_POP) return MAX_POP;
    return pop_size_reg;
  endfunction

  function automatic int unsigned eff_picks();
    int unsigned n;
    n = eff_population();
    if (pick_cnt_reg == 0) return 1;
    if (pick_cnt_reg > n) return n;
    return pick_cnt_reg;
  endfunction

  // One step of the partial shuffle: choose j in [i, n), swap entries i and j,
  // and hand out the entry that has just become final at position i.
  function automatic pick_t draw_next_pick(input logic [FRAC_W-1:0] frac);
    int unsigned n;
    int unsigned k;
    int unsigned i;
    int unsigned j;
    logic [63:0] scaled;
    logic [9:0]  at_i;
    logic [9:0]  at_j;
    pick_t       res;
    n = eff_population();
    k = eff_picks();
    // A population shrunk below the current position restarts the draw.
    if (draw_step >= n) draw_step = '0;
    if (draw_step == 0) entry_live = '0;
    i = draw_step;
    scaled = 64'(frac) * 64'(n - i);
    j = i + int'(scaled >> FRAC_W);
    if (j >= n) j = n - 1;
    // Entries not yet written in this draw stand for their own index.
    at_i = entry_live[i] ? perm_entry[i] : 10'(i);
    at_j = entry_live[j] ? perm_entry[j] : 10'(j);
    perm_entry[j] = at_i;
    entry_live[j] = 1'b1;
    perm_entry[i] = at_j;
    entry_live[i] = 1'b1;
    res.value = VAL_W'(at_j) + VAL_W'(1);
    res.last  = (i + 1) >= k;
    draw_step = res.last ? '0 : CFG_W'(i + 1);
    return res;
  endfunction

  // Driver: a beat that is offered stays offered until it is taken. At the
  // edge that takes it, the shadow works out the pick that it must produce.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_picks.push_back(draw_next_pick(s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (fraction_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= fraction_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, none in a quiet phase, and a long hold-off
  // on request while the driver keeps offering, so that the sampler fills up.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready     <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      m_tready     <= 1'b0;
      hold_left    <= HOLD_CYC;
      holds_served <= holds_served + 1;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 25);
    end
  end

  // Monitor: every result beat is matched against the oldest expected pick.
  always @(posedge clk_i) begin
    pick_t exp_pick;
    if (rst_ni && m_tvalid && m_tready) begin
      if (expected_picks.size() == 0) begin
        $display("%0t: result beat with no pick expected: expected none, actual value %0d last %0b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        exp_pick = expected_picks.pop_front();
        if (m_tdata !== OUT_TDATA_W'(exp_pick.value)) begin
          $display("%0t: picked value mismatch: expected %0d, actual %0d",
                   $time, exp_pick.value, m_tdata);
          errors++;
        end
        if (m_tlast !== exp_pick.last) begin
          $display("%0t: last pick mismatch: expected %0b, actual %0b",
                   $time, exp_pick.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Register write followed by a read-back. The shadow takes the new value at
  // the edge where the write lands; the sampler is idle whenever this runs.
  task automatic reg_write(input pss_reg_e which, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] want;
    want = APB_DATA_W'(value[CFG_W-1:0]);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (which == REG_POPULATION_SIZE) pop_size_reg = value[CFG_W-1:0];
    else pick_cnt_reg = value[CFG_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %s read-back mismatch: expected %0d, actual %0d",
               $time, which.name(), want, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Waits until every fraction has gone in and every pick has come out, then
  // lets the pipeline settle before the registers may be touched again.
  task automatic drain_all();
    while (fraction_q.size() != 0 || s_tvalid || expected_picks.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Mostly uniform fractions, with the ends of the range and single bits mixed in.
  function automatic logic [FRAC_W-1:0] rand_fraction();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return FRAC_W'(1) << $urandom_range(0, FRAC_W - 1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n_eff;
    int unsigned k_eff;
    int unsigned count;
    int unsigned sel;
    logic [APB_DATA_W-1:0] n_val;
    logic [APB_DATA_W-1:0] k_val;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    errors       = 0;
    quiet        = 1'b0;
    holds_asked  = 0;
    pop_size_reg = CFG_W'(MAX_POP);
    pick_cnt_reg = CFG_W'(1);
    entry_live   = '0;
    draw_step    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: single picks out of the full population, extreme fractions.
    fraction_q.push_back(32'h0000_0000);
    fraction_q.push_back(32'hFFFF_FFFF);
    fraction_q.push_back(32'h8000_0000);
    drain_all();

    // Largest population and pick count; the draw is left unfinished.
    reg_write(REG_POPULATION_SIZE, 32'd1024);
    reg_write(REG_PICK_COUNT, 32'd1024);
    fraction_q.push_back(32'hFFFF_FFFF);
    fraction_q.push_back(32'h0000_0000);
    fraction_q.push_back(32'h5555_5555);
    fraction_q.push_back(32'hAAAA_AAAA);
    drain_all();

    // The population shrinks below the current position, so a new draw starts;
    // the pick count exceeds the population and is capped to it.
    reg_write(REG_POPULATION_SIZE, 32'd3);
    reg_write(REG_PICK_COUNT, 32'd2047);
    repeat (4) fraction_q.push_back(32'hFFFF_FFFF);
    drain_all();

    // Zero in both registers counts as one.
    reg_write(REG_POPULATION_SIZE, 32'd0);
    reg_write(REG_PICK_COUNT, 32'd0);
    fraction_q.push_back(32'h1234_5678);
    fraction_q.push_back(32'hFFFF_FFFF);
    drain_all();

    // A population above the store depth is capped at the depth.
    reg_write(REG_POPULATION_SIZE, 32'd2047);
    reg_write(REG_PICK_COUNT, 32'd5);
    fraction_q.push_back(32'h7FFF_FFFF);
    fraction_q.push_back(32'h8000_0000);
    fraction_q.push_back(32'h0000_0001);
    fraction_q.push_back(32'hFFFF_FFFE);
    fraction_q.push_back(32'h0000_0000);
    drain_all();

    // The pick count drops below the current position in mid-draw, so the
    // next pick closes the draw.
    reg_write(REG_POPULATION_SIZE, 32'd16);
    reg_write(REG_PICK_COUNT, 32'd3);
    fraction_q.push_back(32'hC000_0000);
    fraction_q.push_back(32'h3FFF_FFFF);
    drain_all();
    reg_write(REG_PICK_COUNT, 32'd1);
    fraction_q.push_back(32'h9E37_79B9);
    drain_all();

    // Random phases: mostly small populations so that whole draws complete,
    // with a few partial draws left open across register changes.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_PICKS) begin
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) n_val = 32'd0;
        else if (sel == 1) n_val = 32'd2047;
        else if (sel < 14) n_val = $urandom_range(1, 16);
        else if (sel < 18) n_val = $urandom_range(17, 128);
        else n_val = $urandom_range(129, MAX_POP);
        reg_write(REG_POPULATION_SIZE, n_val);
      end
      n_eff = eff_population();
      if (n_eff <= 16 && $urandom_range(0, 7) == 0) k_val = $urandom_range(n_eff, 2047);
      else if ($urandom_range(0, 15) == 0) k_val = 32'd0;
      else k_val = $urandom_range(1, (n_eff < 48) ? n_eff : 48);
      reg_write(REG_PICK_COUNT, k_val);
      k_eff = eff_picks();
      count = k_eff * $urandom_range(1, 3) + $urandom_range(0, 2);
      // The first phase runs with no idling on either side, and the second
      // carries the long hold-off; both must be long enough to matter.
      if (phase == 0 && count < 60) count = 60;
      if (phase == 1) begin
        if (count < 40) count = 40;
        holds_asked = holds_asked + 1;
      end
      if (count > RANDOM_PICKS - sent) count = RANDOM_PICKS - sent;
      quiet = (phase == 0);
      repeat (count) fraction_q.push_back(rand_fraction());
      sent = sent + count;
      drain_all();
      quiet = 1'b0;
      phase++;
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run including the memory sweeps.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
